>>> hdl/led_command_parser_apa102_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the LED command parser.
// Each macro expands to a concurrent assertion clocked on clk and disabled
// while rst_n is low; in synthesis they expand to nothing.
// ---------------------------------------------------------------------------
`ifndef LED_COMMAND_PARSER_APA102_MACROS_SVH
`define LED_COMMAND_PARSER_APA102_MACROS_SVH

`ifndef SYNTHESIS

`define LCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcp assertion failed");

`define LCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcp assertion failed");

`else

`define LCP_ASSERT_IMP(lbl, ante, cons)

`define LCP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hdl/lcp_pkg.sv
// ---------------------------------------------------------------------------
// lcp_pkg
// Types, constants and character tables shared by the LED command parser.
// ---------------------------------------------------------------------------
package lcp_pkg;

    localparam int unsigned LINE_LEN  = 12;
    localparam int unsigned NUM_LEDS  = 3;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] LED_HDR  = 8'hE0;

    localparam logic [4:0] BS_LAST    = 5'd2;
    localparam logic [4:0] ERR_LAST   = 5'd16;
    localparam logic [4:0] FRAME_LAST = 5'd17;
    localparam logic [4:0] POS_FIRST  = 5'd1;
    localparam logic [4:0] POS_LAST   = 5'd11;

    typedef enum logic [2:0] {
        SRC_RX,
        SRC_BS,
        SRC_NL,
        SRC_POS,
        SRC_ERR,
        SRC_FRAME
    } lcp_src_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } lcp_rgb_t;

    typedef struct packed {
        logic       emit;
        logic       last;
        lcp_src_t   src;
        logic [4:0] idx;
        logic       load_rx;
        logic       store_char;
        logic       backspace;
        logic       clear_line;
        logic       set_rainbow;
        logic       set_colour;
        logic       advance_wheel;
        logic       frame_same;
    } lcp_cmd_t;

    typedef struct packed {
        logic       slot_free;
        logic [3:0] line_count;
        logic       rainbow_en;
        logic       hash_ok;
        logic       rbw_ok;
        logic [3:0] fail_pos;
        logic       dn_ok;
    } lcp_status_t;

    function automatic logic [7:0] err_char(input logic [4:0] i);
        logic [7:0] c;
        unique case (i)
            5'd0:    c = 8'h46; // F
            5'd1:    c = 8'h6F; // o
            5'd2:    c = 8'h72; // r
            5'd3:    c = 8'h6D; // m
            5'd4:    c = 8'h61; // a
            5'd5:    c = 8'h74; // t
            5'd6:    c = 8'h3A; // :
            5'd7:    c = 8'h20;
            5'd8:    c = 8'h49; // I
            5'd9:    c = 8'h6E; // n
            5'd10:   c = 8'h76; // v
            5'd11:   c = 8'h61; // a
            5'd12:   c = 8'h6C; // l
            5'd13:   c = 8'h69; // i
            5'd14:   c = 8'h64; // d
            5'd15:   c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

    // Expected character at line positions 1..11 of the rainbow command.
    function automatic logic [7:0] rbw_char(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd1:    c = 8'h46; // F
            4'd2:    c = 8'h55; // U
            4'd3:    c = 8'h4C; // L
            4'd4:    c = 8'h4C; // L
            4'd5:    c = 8'h52; // R
            4'd6:    c = 8'h41; // A
            4'd7:    c = 8'h49; // I
            4'd8:    c = 8'h4E; // N
            4'd9:    c = 8'h42; // B
            4'd10:   c = 8'h4F; // O
            default: c = 8'h57; // W
        endcase
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = (c <= 8'h39) ? (c - 8'h30) : (c - 8'h37);
        return v[3:0];
    endfunction

endpackage

>>> hdl/lcp_datapath.sv
// ---------------------------------------------------------------------------
// lcp_datapath
// Line store, LED colours, wheel position, brightness and the output
// register; builds each output byte from the controller's command.
// ---------------------------------------------------------------------------
`include "led_command_parser_apa102_macros.svh"

module lcp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lcp_pkg::lcp_cmd_t   cmd,
    output lcp_pkg::lcp_status_t st,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_valid,
    input  logic [4:0]          global_brightness,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                channel,
    output logic [7:0]          out_byte,
    output logic                last
);
    import lcp_pkg::*;

    logic [7:0] line_reg [LINE_LEN];
    logic [3:0] count_reg;
    logic       rbw_en_reg;
    logic [7:0] wheel_reg;
    lcp_rgb_t   col_reg [NUM_LEDS];
    logic [4:0] bri_reg;
    logic [7:0] rx_reg;
    logic       out_valid_reg;
    logic       chan_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       slot_free;
    logic [7:0] byte_next;
    logic [3:0] fail;
    logic       rbw_match;
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] q3w;
    logic [7:0] q3;
    lcp_rgb_t   wheel_col;
    lcp_rgb_t   frame_col;
    logic [4:0] foff;
    logic [1:0] led_sel;
    logic [1:0] new_led;
    logic [7:0] led_char;

    assign slot_free = !out_valid_reg || out_ready;

    // Line check on the fixed positions of the store.
    always_comb
    begin
        fail      = 4'd0;
        rbw_match = 1'b1;
        for (int i = 11; i >= 1; i--)
        begin
            if ((i < 9) ? !is_hex(line_reg[i]) : (line_reg[i] != 8'h00))
            begin
                fail = 4'(i);
            end
            if (line_reg[i] != rbw_char(4'(i)))
            begin
                rbw_match = 1'b0;
            end
        end
    end

    assign led_char = line_reg[8];
    assign new_led  = 2'(led_char - CH_SIX);

    assign st.slot_free  = slot_free;
    assign st.line_count = count_reg;
    assign st.rainbow_en = rbw_en_reg;
    assign st.hash_ok    = (line_reg[0] == CH_HASH);
    assign st.rbw_ok     = rbw_match;
    assign st.fail_pos   = fail;
    assign st.dn_ok      = (line_reg[7] == CH_D) && (led_char >= CH_SIX)
                           && (led_char <= CH_EIGHT);

    // Colour wheel: p runs 1..255 and falls into one of three segments.
    always_comb
    begin
        p   = 8'(9'd255 - {1'b0, wheel_reg});
        q   = (p < 8'd85) ? p : ((p < 8'd170) ? (p - 8'd85) : (p - 8'd170));
        q3w = {2'b00, q} + {1'b0, q, 1'b0};
        q3  = q3w[7:0];
        if (p < 8'd85)
        begin
            wheel_col = '{r: 8'd255 - q3, g: 8'd0, b: q3};
        end
        else if (p < 8'd170)
        begin
            wheel_col = '{r: 8'd0, g: q3, b: 8'd255 - q3};
        end
        else
        begin
            wheel_col = '{r: q3, g: 8'd255 - q3, b: 8'd0};
        end
    end

    assign foff      = cmd.idx - 5'd4;
    assign led_sel   = foff[3:2];
    assign frame_col = cmd.frame_same ? wheel_col : col_reg[led_sel];

    always_comb
    begin
        unique case (cmd.src)
            SRC_RX:  byte_next = rx_reg;
            SRC_BS:  byte_next = (cmd.idx == 5'd1) ? CH_SPACE : CH_BS;
            SRC_NL:  byte_next = cmd.idx[0] ? CH_LF : CH_CR;
            SRC_POS: byte_next = line_reg[cmd.idx[3:0]];
            SRC_ERR: byte_next = err_char(cmd.idx);
            SRC_FRAME:
            begin
                if ((cmd.idx < 5'd4) || (cmd.idx > 5'd15))
                begin
                    byte_next = 8'h00;
                end
                else
                begin
                    unique case (foff[1:0])
                        2'd0:    byte_next = LED_HDR | {3'b000, bri_reg};
                        2'd1:    byte_next = frame_col.b;
                        2'd2:    byte_next = frame_col.g;
                        default: byte_next = frame_col.r;
                    endcase
                end
            end
            default: byte_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_LEN; i++)
            begin
                line_reg[i] <= 8'h00;
            end
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                col_reg[i] <= '0;
            end
            count_reg     <= 4'd0;
            rbw_en_reg    <= 1'b0;
            wheel_reg     <= 8'd0;
            bri_reg       <= 5'd7;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bri_reg <= global_brightness;
            end
            if (cmd.store_char)
            begin
                line_reg[count_reg] <= rx_byte;
                count_reg           <= count_reg + 4'd1;
            end
            if (cmd.backspace)
            begin
                line_reg[count_reg - 4'd1] <= 8'h00;
                count_reg                  <= count_reg - 4'd1;
            end
            if (cmd.clear_line)
            begin
                for (int i = 0; i < LINE_LEN; i++)
                begin
                    line_reg[i] <= 8'h00;
                end
                count_reg <= 4'd0;
            end
            if (cmd.set_rainbow)
            begin
                rbw_en_reg <= 1'b1;
                for (int i = 0; i < NUM_LEDS; i++)
                begin
                    col_reg[i] <= '0;
                end
            end
            if (cmd.set_colour)
            begin
                rbw_en_reg       <= 1'b0;
                col_reg[new_led] <= '{r: {hex_val(line_reg[1]), hex_val(line_reg[2])},
                                      g: {hex_val(line_reg[3]), hex_val(line_reg[4])},
                                      b: {hex_val(line_reg[5]), hex_val(line_reg[6])}};
            end
            if (cmd.advance_wheel)
            begin
                wheel_reg <= (wheel_reg == 8'd254) ? 8'd0 : (wheel_reg + 8'd1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rx)
        begin
            rx_reg <= rx_byte;
        end
        if (cmd.emit)
        begin
            chan_reg <= (cmd.src == SRC_FRAME);
            byte_reg <= byte_next;
            last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign channel   = chan_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

    `LCP_ASSERT_IMP(a_count_range, 1'b1, count_reg <= 4'(LINE_LEN))
    `LCP_ASSERT_IMP(a_wheel_range, 1'b1, wheel_reg != 8'd255)
    `LCP_ASSERT_NXT(a_emit_shows, cmd.emit, out_valid_reg)

endmodule

>>> hdl/lcp_ctrl.sv
// ---------------------------------------------------------------------------
// lcp_ctrl
// Sequencer that takes input items and steps through the byte sequences
// of echo, line check, error text and LED frames.
// ---------------------------------------------------------------------------
`include "led_command_parser_apa102_macros.svh"

module lcp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [7:0]           rx_byte,
    input  lcp_pkg::lcp_status_t st,
    output lcp_pkg::lcp_cmd_t    cmd
);
    import lcp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_BS,
        S_NL,
        S_POS,
        S_NL2,
        S_ERR,
        S_FRAME
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] idx_reg, idx_next;
    logic       same_reg, same_next;
    logic       fire;

    assign fire = st.slot_free;

    always_comb
    begin
        cmd            = '0;
        cmd.src        = SRC_RX;
        cmd.idx        = idx_reg;
        cmd.frame_same = same_reg;
        in_ready       = 1'b0;
        state_next     = state_reg;
        idx_next       = idx_reg;
        same_next      = same_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                idx_next = 5'd0;
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        if (st.rainbow_en)
                        begin
                            cmd.advance_wheel = 1'b1;
                            same_next         = 1'b1;
                            state_next        = S_FRAME;
                        end
                    end
                    else if ((rx_byte == CH_CR) || (rx_byte == CH_LF))
                    begin
                        state_next = S_NL;
                    end
                    else if ((rx_byte == CH_BS) || (rx_byte == CH_DEL))
                    begin
                        if (st.line_count != 4'd0)
                        begin
                            cmd.backspace = 1'b1;
                            state_next    = S_BS;
                        end
                    end
                    else if (st.line_count < 4'(LINE_LEN))
                    begin
                        cmd.store_char = 1'b1;
                        cmd.load_rx    = 1'b1;
                        state_next     = S_ECHO;
                    end
                end
            end
            S_ECHO:
            begin
                cmd.emit = fire;
                cmd.last = 1'b1;
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BS:
            begin
                cmd.src  = SRC_BS;
                cmd.emit = fire;
                cmd.last = (idx_reg == BS_LAST);
                if (fire)
                begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == BS_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_NL:
            begin
                cmd.src  = SRC_NL;
                cmd.emit = fire;
                cmd.last = idx_reg[0] && st.hash_ok && st.rbw_ok;
                if (fire)
                begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg[0])
                    begin
                        if (!st.hash_ok)
                        begin
                            idx_next   = 5'd0;
                            state_next = S_ERR;
                        end
                        else if (st.rbw_ok)
                        begin
                            cmd.set_rainbow = 1'b1;
                            cmd.clear_line  = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = POS_FIRST;
                            state_next = S_POS;
                        end
                    end
                end
            end
            S_POS:
            begin
                cmd.src  = SRC_POS;
                cmd.emit = fire;
                if (fire)
                begin
                    idx_next = idx_reg + 5'd1;
                    if ({1'b0, st.fail_pos} == idx_reg)
                    begin
                        idx_next   = 5'd0;
                        state_next = S_ERR;
                    end
                    else if (idx_reg == POS_LAST)
                    begin
                        idx_next   = 5'd0;
                        state_next = S_NL2;
                    end
                end
            end
            S_NL2:
            begin
                cmd.src  = SRC_NL;
                cmd.emit = fire;
                if (fire)
                begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg[0])
                    begin
                        idx_next = 5'd0;
                        if (st.dn_ok)
                        begin
                            cmd.set_colour = 1'b1;
                            cmd.clear_line = 1'b1;
                            same_next      = 1'b0;
                            state_next     = S_FRAME;
                        end
                        else
                        begin
                            state_next = S_ERR;
                        end
                    end
                end
            end
            S_ERR:
            begin
                cmd.src  = SRC_ERR;
                cmd.emit = fire;
                cmd.last = (idx_reg == ERR_LAST);
                if (fire)
                begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == ERR_LAST)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_FRAME:
            begin
                cmd.src  = SRC_FRAME;
                cmd.emit = fire;
                cmd.last = (idx_reg == FRAME_LAST);
                if (fire)
                begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == FRAME_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 5'd0;
            same_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            same_reg  <= same_next;
        end
    end

    `LCP_ASSERT_IMP(a_emit_free, cmd.emit, st.slot_free)
    `LCP_ASSERT_NXT(a_last_idle, cmd.emit && cmd.last, state_reg == S_IDLE)
    `LCP_ASSERT_IMP(a_pos_range, state_reg == S_POS,
                    (idx_reg >= POS_FIRST) && (idx_reg <= POS_LAST))

endmodule

>>> hdl/led_command_parser_apa102.sv
// ---------------------------------------------------------------------------
// led_command_parser_apa102
// Command-line parser for UART bytes and APA102 LED frame driver with a
// colour-wheel rainbow mode.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_ready  | req_type, rx_byte
//  out     | out_valid / out_ready| channel, out_byte, last
//  cfg     | cfg_valid / cfg_ready| global_brightness
//
// The sequencer holds one item at a time and steps through its result
// bytes in order; it takes a new item only once the last result byte of
// the current one has been issued.
// A stall on out_ready holds the sequencer with the output register.
// Reset is asynchronous; it clears the line, the colours, rainbow mode and
// the wheel, and sets the brightness to 7. Configuration is always ready.
// ---------------------------------------------------------------------------
module led_command_parser_apa102 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       channel,
    output logic [7:0] out_byte,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] global_brightness
);
    import lcp_pkg::*;

    lcp_cmd_t    cmd;
    lcp_status_t st;

    assign cfg_ready = 1'b1;

    lcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .rx_byte  (rx_byte),
        .st       (st),
        .cmd      (cmd)
    );

    lcp_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .rx_byte           (rx_byte),
        .cfg_valid         (cfg_valid),
        .global_brightness (global_brightness),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .channel           (channel),
        .out_byte          (out_byte),
        .last              (last)
    );

endmodule

>>> sim/led_command_parser_apa102_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// led_command_parser_apa102_tb
// Self-checking bench for the LED command parser: command lines, line
// edits, rainbow ticks and brightness writes go in, and every UART and SPI
// byte that comes out is compared with a behavioral prediction.
// ---------------------------------------------------------------------------
module led_command_parser_apa102_tb;
    import lcp_pkg::*;

    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam logic CH_UART  = 1'b0;
    localparam logic CH_SPI   = 1'b1;
    localparam int   DRAIN_CYCLES = 40;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
    } req_item_t;

    typedef struct packed {
        logic       chan;
        logic [7:0] data;
        logic       last;
    } tx_byte_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic       channel;
    logic [7:0] out_byte;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] brightness_wr;

    req_item_t pending_q[$];
    tx_byte_t  tx_expect_q[$];
    int        idle_mode;
    bit        failed;

    // Predictor state.
    logic [7:0] line_buf[LINE_LEN];
    int         line_len;
    bit         rainbow_on;
    int         wheel;
    logic [7:0] led_rgb[3 * NUM_LEDS];
    logic [4:0] brightness;

    led_command_parser_apa102 i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .channel           (channel),
        .out_byte          (out_byte),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .global_brightness (brightness_wr)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    function automatic void push_tx(input logic ch, input logic [7:0] b);
        tx_byte_t t;
        t.chan = ch;
        t.data = b;
        t.last = 1'b0;
        tx_expect_q.push_back(t);
    endfunction

    function automatic void push_led_frame(input bit same, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
        for (int i = 0; i < 4; i++) push_tx(CH_SPI, 8'h00);
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            push_tx(CH_SPI, LED_HDR | {3'b000, brightness});
            push_tx(CH_SPI, same ? b : led_rgb[3 * i + 2]);
            push_tx(CH_SPI, same ? g : led_rgb[3 * i + 1]);
            push_tx(CH_SPI, same ? r : led_rgb[3 * i]);
        end
        push_tx(CH_SPI, 8'h00);
        push_tx(CH_SPI, 8'h00);
    endfunction

    function automatic bit hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        return (c <= "9") ? 4'(c - "0") : 4'(c - "A" + 10);
    endfunction

    // Returns 1 when the finished line was a valid command.
    function automatic bit run_line();
        string rbw;
        bit    match;
        int    led;
        rbw = "FULLRAINBOW";
        if (line_buf[0] != CH_HASH) return 0;
        match = 1;
        for (int i = 1; i < LINE_LEN; i++)
            if (line_buf[i] != rbw[i - 1]) match = 0;
        if (match)
        begin
            rainbow_on = 1;
            for (int i = 0; i < 3 * NUM_LEDS; i++) led_rgb[i] = 8'h00;
            return 1;
        end
        for (int i = 1; i < LINE_LEN; i++)
        begin
            push_tx(CH_UART, line_buf[i]);
            if (i < 9 ? !hex_char(line_buf[i]) : line_buf[i] != 8'h00) return 0;
        end
        push_tx(CH_UART, CH_CR);
        push_tx(CH_UART, CH_LF);
        if (line_buf[7] != CH_D) return 0;
        if (line_buf[8] < CH_SIX || line_buf[8] > CH_EIGHT) return 0;
        led = line_buf[8] - CH_SIX;
        led_rgb[3 * led]     = {nibble(line_buf[1]), nibble(line_buf[2])};
        led_rgb[3 * led + 1] = {nibble(line_buf[3]), nibble(line_buf[4])};
        led_rgb[3 * led + 2] = {nibble(line_buf[5]), nibble(line_buf[6])};
        rainbow_on = 0;
        push_led_frame(0, 8'h00, 8'h00, 8'h00);
        return 1;
    endfunction

    function automatic void predict_item(input req_item_t it);
        int    start;
        int    p;
        int    q;
        string err;
        start = tx_expect_q.size();
        err = "Format: Invalid";
        if (it.req == REQ_TICK)
        begin
            if (rainbow_on)
            begin
                wheel = (wheel + 1) % 255;
                p = 255 - wheel;
                if (p < 85)
                    push_led_frame(1, 8'(255 - 3 * p), 8'h00, 8'(3 * p));
                else if (p < 170)
                begin
                    q = p - 85;
                    push_led_frame(1, 8'h00, 8'(3 * q), 8'(255 - 3 * q));
                end
                else
                begin
                    q = p - 170;
                    push_led_frame(1, 8'(3 * q), 8'(255 - 3 * q), 8'h00);
                end
            end
        end
        else if (it.data == CH_CR || it.data == CH_LF)
        begin
            push_tx(CH_UART, CH_CR);
            push_tx(CH_UART, CH_LF);
            if (!run_line())
            begin
                for (int i = 0; i < err.len(); i++) push_tx(CH_UART, err[i]);
                push_tx(CH_UART, CH_CR);
                push_tx(CH_UART, CH_LF);
            end
            for (int i = 0; i < LINE_LEN; i++) line_buf[i] = 8'h00;
            line_len = 0;
        end
        else if (it.data == CH_BS || it.data == CH_DEL)
        begin
            if (line_len > 0)
            begin
                push_tx(CH_UART, CH_BS);
                push_tx(CH_UART, CH_SPACE);
                push_tx(CH_UART, CH_BS);
                line_len--;
                line_buf[line_len] = 8'h00;
            end
        end
        else if (line_len < LINE_LEN)
        begin
            push_tx(CH_UART, it.data);
            line_buf[line_len] = it.data;
            line_len++;
        end
        if (tx_expect_q.size() > start) tx_expect_q[tx_expect_q.size() - 1].last = 1'b1;
    endfunction

    // Sender side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_RX;
            rx_byte  <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready) predict_item('{req: req_type, data: rx_byte});
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() > 0 &&
                    !(idle_mode == 0 && $urandom_range(99) < 27) &&
                    !(idle_mode == 1 && $urandom_range(99) < 49))
                begin
                    in_valid <= 1'b1;
                    req_type <= pending_q[0].req;
                    rx_byte  <= pending_q[0].data;
                    void'(pending_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver side and checking.
    always @(posedge clk or negedge rst_n)
    begin
        tx_byte_t t;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tx_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected byte chan=%0d data=%02h last=%0d",
                             $time, channel, out_byte, last);
                    failed = 1;
                end
                else
                begin
                    t = tx_expect_q.pop_front();
                    if (channel !== t.chan || out_byte !== t.data || last !== t.last)
                    begin
                        $display({"%0t: mismatch expected chan=%0d data=%02h last=%0d,",
                                  " got chan=%0d data=%02h last=%0d"},
                                 $time, t.chan, t.data, t.last, channel, out_byte, last);
                        failed = 1;
                    end
                end
            end
            out_ready <= !((idle_mode == 0 && $urandom_range(99) < 49) ||
                           (idle_mode == 1 && $urandom_range(99) < 27));
        end
    end

    function automatic void queue_rx(input logic [7:0] c);
        pending_q.push_back('{req: REQ_RX, data: c});
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_rx(s[i]);
    endfunction

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789ABCDEF";
        return digits[$urandom_range(15)];
    endfunction

    // Random traffic; returns once at least n items are queued.
    function automatic void queue_random(input int n);
        int         added;
        int         kind;
        int         k;
        logic [7:0] cmd[10];
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                cmd[0] = CH_HASH;
                for (int i = 1; i < 7; i++) cmd[i] = rand_hex();
                cmd[7] = CH_D;
                cmd[8] = 8'($urandom_range(CH_SIX, CH_EIGHT));
                cmd[9] = $urandom_range(1) ? CH_CR : CH_LF;
                if ($urandom_range(5) == 0) cmd[$urandom_range(8)] = 8'($urandom);
                for (int i = 0; i < 10; i++) queue_rx(cmd[i]);
                added += 10;
            end
            else if (kind < 45)
            begin
                queue_text("#FULLRAINBOW");
                queue_rx($urandom_range(1) ? CH_CR : CH_LF);
                added += 13;
            end
            else if (kind < 75)
            begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++) pending_q.push_back('{req: REQ_TICK, data: 8'($urandom)});
                added += k;
            end
            else if (kind < 85)
            begin
                queue_text("#12");
                queue_rx($urandom_range(1) ? CH_BS : CH_DEL);
                queue_rx(rand_hex());
                queue_rx($urandom_range(1) ? CH_BS : CH_DEL);
                added += 6;
            end
            else
            begin
                k = $urandom_range(1, 5);
                for (int i = 0; i < k; i++) queue_rx(8'($urandom));
                added += k;
            end
        end
    endfunction

    task automatic wait_idle();
        while (pending_q.size() > 0 || in_valid || tx_expect_q.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_brightness(input logic [4:0] v);
        cfg_valid     <= 1'b1;
        brightness_wr <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        brightness = v;
    endtask

    initial
    begin
        failed     = 0;
        idle_mode  = 0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        brightness_wr = 5'd0;
        for (int i = 0; i < LINE_LEN; i++) line_buf[i] = 8'h00;
        for (int i = 0; i < 3 * NUM_LEDS; i++) led_rgb[i] = 8'h00;
        line_len   = 0;
        rainbow_on = 0;
        wheel      = 0;
        brightness = 5'd7;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset brightness, then at full brightness.
        pending_q.push_back('{req: REQ_TICK, data: 8'h00});
        queue_rx(CH_BS);
        queue_text("#FF00A5D6\r");
        wait_idle();
        write_brightness(5'd31);
        queue_text("#FULLRAINBOW\n");
        pending_q.push_back('{req: REQ_TICK, data: 8'hFF});
        queue_text("#012345D8\n#ABCDEFD7\r");
        queue_text("X\r\r#GG\r#12345678\r#123456D9\r#12345678901\r");
        queue_text("#123456D6xyzW\r");
        queue_rx(8'h00);
        queue_rx(8'hFF);
        queue_rx(CH_DEL);
        queue_rx(CH_LF);
        wait_idle();

        write_brightness(5'd0);
        queue_random(85);
        wait_idle();

        idle_mode = 1;
        write_brightness(5'd17);
        queue_random(85);
        wait_idle();

        idle_mode = 2;
        write_brightness(5'($urandom));
        queue_random(85);
        wait_idle();

        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
